FILE: rtl/c_comment_char_classifier_defines.svh
// Shared assertion macros for the comment classifier.
`ifndef C_COMMENT_CHAR_CLASSIFIER_DEFINES_SVH
`define C_COMMENT_CHAR_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ccc_pkg.sv
`default_nettype none

package ccc_pkg;

    localparam logic [7:0] C_DQUOTE    = 8'h22;
    localparam logic [7:0] C_SQUOTE    = 8'h27;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_STAR      = 8'h2A;
    localparam logic [7:0] C_SLASH     = 8'h2F;
    localparam logic [7:0] C_NEWLINE   = 8'h0A;

    typedef enum logic [2:0] {
        CLS_DQUOTE    = 3'd0,
        CLS_SQUOTE    = 3'd1,
        CLS_BACKSLASH = 3'd2,
        CLS_STAR      = 3'd3,
        CLS_SLASH     = 3'd4,
        CLS_NEWLINE   = 3'd5,
        CLS_OTHER     = 3'd6
    } t_byte_class;

    typedef enum logic [3:0] {
        ST_CODE      = 4'd0,
        ST_AFTERBLK  = 4'd1,
        ST_STR       = 4'd2,
        ST_STRESC    = 4'd3,
        ST_CHR       = 4'd4,
        ST_CHRESC    = 4'd5,
        ST_CHRFULL   = 4'd6,
        ST_CHRFULLE  = 4'd7,
        ST_SLASH     = 4'd8,
        ST_LINE      = 4'd9,
        ST_BLOCK     = 4'd10,
        ST_BLKSTAR   = 4'd11,
        ST_ERR       = 4'd12
    } t_lex_state;

    typedef struct packed {
        logic        step;
        t_byte_class cls;
    } t_fsm_ctl;

endpackage

`default_nettype wire

FILE: rtl/c_comment_char_classifier.sv
// Comment classifier for a C source byte stream.
//
// Input channel: i_valid / o_ready carry one source byte, i_char_in, per transfer.
// Output channel: o_valid / i_ready carry one bit, o_prev_in_comment, per input byte.
// The bit says whether the previous byte was comment text, so an opening slash is
// flagged with the byte after it and the byte after a closing star-slash is flagged.
// Pipeline: a byte is registered in the input register on transfer, then its bit is
// registered in the result register once the result register is free.
// Throughput: one byte per cycle while the receiver takes each result; the lexer state
// update is a single table lookup between the input register and the result register.
// Reset (synchronous, active low) empties both registers and returns the lexer to
// plain code; it is also the only exit from the sticky error state, which reports 0.
// When the receiver stalls, the result holds, the input register fills, and o_ready
// drops until the result is taken.
`default_nettype none
`include "c_comment_char_classifier_defines.svh"

module c_comment_char_classifier (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_char_in,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_prev_in_comment
);
    import ccc_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_out_valid;
    logic        r_out_flag;

    logic        adv_out;
    logic        flag;
    t_byte_class cls;
    t_fsm_ctl    ctl;

    assign adv_out = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || adv_out;

    ccc_class u_class (
        .i_char  (r_char),
        .o_class (cls)
    );

    assign ctl.step = r_in_valid && adv_out;
    assign ctl.cls  = cls;

    ccc_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_flag  (flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char_in;
        end
        if (ctl.step) begin
            r_out_flag <= flag;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_prev_in_comment = r_out_flag;

    `CCC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !o_ready, r_in_valid && $stable(r_char), "input register lost its byte")
    `CCC_ASSERT_NEXT(a_in_load, i_clk, i_rst_n, o_ready && i_valid, r_in_valid, "accepted byte not registered")
    `CCC_ASSERT_SAME(a_ready_free, i_clk, i_rst_n, !r_out_valid, o_ready, "not ready with empty result register")

endmodule

`default_nettype wire

FILE: rtl/ccc_class.sv
`default_nettype none

module ccc_class (
    input  wire logic [7:0]          i_char,
    output ccc_pkg::t_byte_class     o_class
);
    import ccc_pkg::*;

    always_comb begin
        unique case (i_char)
            C_DQUOTE:    o_class = CLS_DQUOTE;
            C_SQUOTE:    o_class = CLS_SQUOTE;
            C_BACKSLASH: o_class = CLS_BACKSLASH;
            C_STAR:      o_class = CLS_STAR;
            C_SLASH:     o_class = CLS_SLASH;
            C_NEWLINE:   o_class = CLS_NEWLINE;
            default:     o_class = CLS_OTHER;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ccc_fsm.sv
`default_nettype none
`include "c_comment_char_classifier_defines.svh"

module ccc_fsm (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ccc_pkg::t_fsm_ctl i_ctl,
    output logic               o_flag
);
    import ccc_pkg::*;

    t_lex_state r_state;
    t_lex_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CODE;
        end else if (i_ctl.step) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = ST_ERR;
        unique case (r_state)
            ST_CODE, ST_AFTERBLK: begin
                unique case (i_ctl.cls)
                    CLS_DQUOTE:    n_state = ST_STR;
                    CLS_SQUOTE:    n_state = ST_CHR;
                    CLS_BACKSLASH: n_state = ST_ERR;
                    CLS_SLASH:     n_state = ST_SLASH;
                    default:       n_state = ST_CODE;
                endcase
            end
            ST_STR: begin
                unique case (i_ctl.cls)
                    CLS_DQUOTE:    n_state = ST_CODE;
                    CLS_BACKSLASH: n_state = ST_STRESC;
                    CLS_NEWLINE:   n_state = ST_ERR;
                    default:       n_state = ST_STR;
                endcase
            end
            ST_STRESC: n_state = ST_STR;
            ST_CHR: begin
                unique case (i_ctl.cls)
                    CLS_SQUOTE, CLS_NEWLINE: n_state = ST_ERR;
                    CLS_BACKSLASH:           n_state = ST_CHRESC;
                    default:                 n_state = ST_CHRFULL;
                endcase
            end
            ST_CHRESC: begin
                n_state = (i_ctl.cls == CLS_NEWLINE) ? ST_CHR : ST_CHRFULL;
            end
            ST_CHRFULL: begin
                unique case (i_ctl.cls)
                    CLS_SQUOTE:    n_state = ST_CODE;
                    CLS_BACKSLASH: n_state = ST_CHRFULLE;
                    default:       n_state = ST_ERR;
                endcase
            end
            ST_CHRFULLE: begin
                n_state = (i_ctl.cls == CLS_NEWLINE) ? ST_CHRFULL : ST_ERR;
            end
            ST_SLASH: begin
                unique case (i_ctl.cls)
                    CLS_STAR:  n_state = ST_BLOCK;
                    CLS_SLASH: n_state = ST_LINE;
                    default:   n_state = ST_CODE;
                endcase
            end
            ST_LINE: begin
                n_state = (i_ctl.cls == CLS_NEWLINE) ? ST_CODE : ST_LINE;
            end
            ST_BLOCK: begin
                n_state = (i_ctl.cls == CLS_STAR) ? ST_BLKSTAR : ST_BLOCK;
            end
            ST_BLKSTAR: begin
                unique case (i_ctl.cls)
                    CLS_STAR:  n_state = ST_BLKSTAR;
                    CLS_SLASH: n_state = ST_AFTERBLK;
                    default:   n_state = ST_BLOCK;
                endcase
            end
            default: n_state = ST_ERR;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_AFTERBLK, ST_LINE, ST_BLOCK, ST_BLKSTAR: o_flag = 1'b1;
            ST_SLASH: o_flag = (i_ctl.cls == CLS_STAR) || (i_ctl.cls == CLS_SLASH);
            default:  o_flag = 1'b0;
        endcase
    end

    `CCC_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_state == ST_ERR, r_state == ST_ERR, "error state left without reset")
    `CCC_ASSERT_NEXT(a_hold_no_step, i_clk, i_rst_n, !i_ctl.step, $stable(r_state), "state moved without a transfer")
    `CCC_ASSERT_NEXT(a_block_stays, i_clk, i_rst_n, i_ctl.step && r_state == ST_BLOCK && i_ctl.cls != CLS_STAR, r_state == ST_BLOCK, "block comment left without star")

endmodule

`default_nettype wire
